// ----- design/tws_pkg.sv -----
package tws_pkg;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_A_SETUP = 4'd1,
    PH_A_HIGH  = 4'd2,
    PH_A_LOW   = 4'd3,
    PH_TURN    = 4'd4,
    PH_D_SETUP = 4'd5,
    PH_D_HIGH  = 4'd6,
    PH_D_LOW   = 4'd7,
    PH_R_HIGH  = 4'd8,
    PH_R_LOW   = 4'd9,
    PH_S_HIGH  = 4'd10,
    PH_S_LOW   = 4'd11,
    PH_RECOVER = 4'd12
  } phase_t;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_WRITE  = 2'd2;
  localparam logic [1:0] ACT_RESYNC = 2'd3;

  localparam logic [2:0] REG_CLOCK_HIGH = 3'd0;
  localparam logic [2:0] REG_CLOCK_LOW  = 3'd1;
  localparam logic [2:0] REG_SETUP      = 3'd2;
  localparam logic [2:0] REG_READ_TURN  = 3'd3;
  localparam logic [2:0] REG_WRITE_TURN = 3'd4;
  localparam logic [2:0] REG_RECOVERY   = 3'd5;

  localparam logic [5:0] RESYNC_PULSES = 6'd20;

  typedef struct packed {
    logic [9:0] clock_high;
    logic [9:0] clock_low;
    logic [9:0] setup;
    logic [9:0] read_turn;
    logic [9:0] write_turn;
    logic [9:0] recovery;
  } cfg_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] bit_index;
    logic [7:0] shift_byte;
    logic [7:0] received_byte;
    logic [9:0] tick_count;
    logic [5:0] pulse_count;
    logic       is_read;
    logic [7:0] held_write_data;
    logic       clock_out;
    logic       drive_out;
  } seq_state_t;

  typedef struct packed {
    logic       clock_level;
    logic       data_level;
    logic       data_drive;
    logic       busy;
    logic       done;
    logic [7:0] rx_data;
  } result_t;

  localparam cfg_t CFG_RESET = '{
    clock_high: 10'd1, clock_low: 10'd1, setup: 10'd1,
    read_turn: 10'd4, write_turn: 10'd4, recovery: 10'd4
  };

  localparam seq_state_t SEQ_RESET = '{
    phase: PH_IDLE, bit_index: 3'd7, shift_byte: 8'd0, received_byte: 8'd0,
    tick_count: 10'd0, pulse_count: 6'd0, is_read: 1'b0, held_write_data: 8'd0,
    clock_out: 1'b0, drive_out: 1'b1
  };

  function automatic logic [9:0] at_least_one(input logic [9:0] v);
    return (v == 10'd0) ? 10'd1 : v;
  endfunction

  function automatic logic is_high_phase(input phase_t p);
    return (p == PH_A_HIGH) || (p == PH_D_HIGH) || (p == PH_R_HIGH) || (p == PH_S_HIGH);
  endfunction

endpackage

// ----- design/two_wire_serial_register_master.sv -----
// A result is registered when its request is accepted and shows on the outputs in the cycle after.
// Throughput: one request per cycle while out_ready is high; the sequencer step is a single pass
// through tws_step between the state registers and the result register.
// Reset (rst_n low, synchronous): timing registers return to 1,1,1,4,4,4,
// the sequencer goes idle with clock low and data driven low.
module two_wire_serial_register_master (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [6:0]  in_address,
  input  logic [7:0]  in_write_data,
  input  logic        in_data_line_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_clock_level,
  output logic        out_data_level,
  output logic        out_data_drive,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [7:0]  out_read_byte_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tws_pkg::cfg_t       cfg_r;
  tws_pkg::seq_state_t state_r;
  tws_pkg::seq_state_t state_nxt;
  tws_pkg::result_t    res_nxt;
  tws_pkg::result_t    res_r;
  logic                out_valid_r;
  logic                accept;
  logic                cfg_write;
  logic [2:0]          reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= tws_pkg::CFG_RESET;
    end else if (cfg_write) begin
      case (reg_index)
        tws_pkg::REG_CLOCK_HIGH: cfg_r.clock_high <= pwdata[9:0];
        tws_pkg::REG_CLOCK_LOW:  cfg_r.clock_low  <= pwdata[9:0];
        tws_pkg::REG_SETUP:      cfg_r.setup      <= pwdata[9:0];
        tws_pkg::REG_READ_TURN:  cfg_r.read_turn  <= pwdata[9:0];
        tws_pkg::REG_WRITE_TURN: cfg_r.write_turn <= pwdata[9:0];
        tws_pkg::REG_RECOVERY:   cfg_r.recovery   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      tws_pkg::REG_CLOCK_HIGH: prdata = {22'd0, cfg_r.clock_high};
      tws_pkg::REG_CLOCK_LOW:  prdata = {22'd0, cfg_r.clock_low};
      tws_pkg::REG_SETUP:      prdata = {22'd0, cfg_r.setup};
      tws_pkg::REG_READ_TURN:  prdata = {22'd0, cfg_r.read_turn};
      tws_pkg::REG_WRITE_TURN: prdata = {22'd0, cfg_r.write_turn};
      tws_pkg::REG_RECOVERY:   prdata = {22'd0, cfg_r.recovery};
      default:                 prdata = 32'd0;
    endcase
  end

  // take a new request whenever the result register is empty or draining
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  tws_step u_step (
    .cur          (state_r),
    .cfg          (cfg_r),
    .action       (in_action),
    .address      (in_address),
    .write_data   (in_write_data),
    .data_line_in (in_data_line_in),
    .nxt          (state_nxt),
    .res          (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tws_pkg::SEQ_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_clock_level   = res_r.clock_level;
  assign out_data_level    = res_r.data_level;
  assign out_data_drive    = res_r.data_drive;
  assign out_busy_res      = res_r.busy;
  assign out_done_res      = res_r.done;
  assign out_read_byte_out = res_r.rx_data;

endmodule

// ----- design/tws_step.sv -----
module tws_step (
  input  tws_pkg::seq_state_t cur,
  input  tws_pkg::cfg_t       cfg,
  input  logic [1:0]          action,
  input  logic [6:0]          address,
  input  logic [7:0]          write_data,
  input  logic                data_line_in,
  output tws_pkg::seq_state_t nxt,
  output tws_pkg::result_t    res
);

  always_comb begin
    tws_pkg::seq_state_t t;
    tws_pkg::phase_t     np;
    logic                leave_turn;
    logic [9:0]          len;
    logic [9:0]          tick;
    logic [9:0]          turn_len;

    t          = cur;
    np         = tws_pkg::PH_IDLE;
    leave_turn = 1'b0;
    len        = 10'd0;
    tick       = 10'd0;
    turn_len   = 10'd0;
    res        = '0;

    // start request only takes effect from idle
    if (t.phase == tws_pkg::PH_IDLE && action != tws_pkg::ACT_TICK) begin
      t.drive_out  = 1'b1;
      t.bit_index  = 3'd7;
      t.tick_count = 10'd0;
      if (action == tws_pkg::ACT_RESYNC) begin
        t.is_read     = 1'b0;
        t.shift_byte  = 8'hFF;
        t.pulse_count = 6'd0;
        t.phase       = tws_pkg::PH_S_HIGH;
        t.clock_out   = 1'b1;
      end else begin
        t.is_read         = (action == tws_pkg::ACT_READ);
        t.shift_byte      = {~t.is_read, address};
        t.held_write_data = write_data;
        if (cfg.setup == 10'd0) begin
          t.phase     = tws_pkg::PH_A_HIGH;
          t.clock_out = 1'b1;
        end else begin
          t.phase     = tws_pkg::PH_A_SETUP;
          t.clock_out = 1'b0;
        end
      end
    end

    res.clock_level = t.clock_out;
    res.data_drive  = t.drive_out;
    res.data_level  = t.drive_out & t.shift_byte[t.bit_index];
    res.busy        = (t.phase != tws_pkg::PH_IDLE);

    if (t.phase != tws_pkg::PH_IDLE) begin
      case (t.phase)
        tws_pkg::PH_A_SETUP, tws_pkg::PH_D_SETUP: len = cfg.setup;
        tws_pkg::PH_A_HIGH, tws_pkg::PH_D_HIGH, tws_pkg::PH_R_HIGH, tws_pkg::PH_S_HIGH:
          len = tws_pkg::at_least_one(cfg.clock_high);
        tws_pkg::PH_A_LOW, tws_pkg::PH_D_LOW, tws_pkg::PH_R_LOW, tws_pkg::PH_S_LOW:
          len = tws_pkg::at_least_one(cfg.clock_low);
        tws_pkg::PH_TURN:    len = t.is_read ? cfg.read_turn : cfg.write_turn;
        tws_pkg::PH_RECOVER: len = cfg.recovery;
        default:             len = 10'd1;
      endcase

      tick         = t.tick_count + 10'd1;
      t.tick_count = tick;

      if (tick >= len) begin
        if (t.phase == tws_pkg::PH_R_HIGH && data_line_in) begin
          t.shift_byte[t.bit_index] = 1'b1;
        end

        case (t.phase)
          tws_pkg::PH_A_SETUP: np = tws_pkg::PH_A_HIGH;
          tws_pkg::PH_A_HIGH:  np = tws_pkg::PH_A_LOW;
          tws_pkg::PH_A_LOW: begin
            if (t.bit_index != 3'd0) begin
              t.bit_index = t.bit_index - 3'd1;
              np = tws_pkg::PH_A_SETUP;
            end else begin
              np = tws_pkg::PH_TURN;
            end
          end
          tws_pkg::PH_TURN:    leave_turn = 1'b1;
          tws_pkg::PH_D_SETUP: np = tws_pkg::PH_D_HIGH;
          tws_pkg::PH_D_HIGH:  np = tws_pkg::PH_D_LOW;
          tws_pkg::PH_D_LOW: begin
            if (t.bit_index != 3'd0) begin
              t.bit_index = t.bit_index - 3'd1;
              np = tws_pkg::PH_D_SETUP;
            end else begin
              np = tws_pkg::PH_RECOVER;
            end
          end
          tws_pkg::PH_R_HIGH: np = tws_pkg::PH_R_LOW;
          tws_pkg::PH_R_LOW: begin
            if (t.bit_index != 3'd0) begin
              t.bit_index = t.bit_index - 3'd1;
              np = tws_pkg::PH_R_HIGH;
            end else begin
              t.received_byte = t.shift_byte;
              np = tws_pkg::PH_RECOVER;
            end
          end
          tws_pkg::PH_S_HIGH: np = tws_pkg::PH_S_LOW;
          tws_pkg::PH_S_LOW: begin
            t.pulse_count = t.pulse_count + 6'd1;
            np = (t.pulse_count < tws_pkg::RESYNC_PULSES) ? tws_pkg::PH_S_HIGH
                                                          : tws_pkg::PH_RECOVER;
          end
          default: np = tws_pkg::PH_IDLE;
        endcase

        // skip phases of zero length; turnaround first, since on a write it leads to data setup
        turn_len = t.is_read ? cfg.read_turn : cfg.write_turn;
        if (np == tws_pkg::PH_TURN && turn_len == 10'd0) begin
          leave_turn = 1'b1;
        end
        if (leave_turn) begin
          t.bit_index = 3'd7;
          if (t.is_read) begin
            t.shift_byte = 8'd0;
            t.drive_out  = 1'b0;
            np = tws_pkg::PH_R_HIGH;
          end else begin
            t.shift_byte = t.held_write_data;
            np = tws_pkg::PH_D_SETUP;
          end
        end
        if (np == tws_pkg::PH_A_SETUP && cfg.setup == 10'd0) begin
          np = tws_pkg::PH_A_HIGH;
        end
        if (np == tws_pkg::PH_D_SETUP && cfg.setup == 10'd0) begin
          np = tws_pkg::PH_D_HIGH;
        end
        if (np == tws_pkg::PH_RECOVER && cfg.recovery == 10'd0) begin
          np = tws_pkg::PH_IDLE;
        end

        t.tick_count = 10'd0;
        t.phase      = np;
        t.clock_out  = tws_pkg::is_high_phase(np);
        res.done     = (np == tws_pkg::PH_IDLE);
      end
    end

    res.rx_data = t.received_byte;
    nxt         = t;
  end

endmodule

// ----- design/tws_checker.sv -----
module tws_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_clock_level,
  input logic       out_data_level,
  input logic       out_data_drive,
  input logic       out_busy_res,
  input logic       out_done_res,
  input logic [7:0] out_read_byte_out
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_clock_level) &&
      $stable(out_data_level) && $stable(out_data_drive) && $stable(out_busy_res) &&
      $stable(out_done_res) && $stable(out_read_byte_out))
    else $error("stalled result changed");

  // every accepted request shows its result on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

  // an empty result register never blocks the input side
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // completion only on a busy tick with the clock low
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_busy_res && !out_clock_level)
    else $error("done outside a clock-low busy tick");

endmodule

bind two_wire_serial_register_master tws_checker u_tws_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_clock_level   (out_clock_level),
  .out_data_level    (out_data_level),
  .out_data_drive    (out_data_drive),
  .out_busy_res      (out_busy_res),
  .out_done_res      (out_done_res),
  .out_read_byte_out (out_read_byte_out)
);
